// ----- hdl/ugm_pkg.sv -----
// ----------------------------------------------------------------------------
// ugm_pkg
// Shared constants, widths and controller/datapath interface types for the
// unit group product table block.
// ----------------------------------------------------------------------------
package ugm_pkg;

    // largest modulus handled; larger register values saturate to this
    localparam int MAX_MODULUS = 256;

    // field widths
    localparam int MOD_W   = 9;                        // modulus register
    localparam int RES_W   = 8;                        // residue, rank, count
    localparam int ADDR_W  = $clog2(MAX_MODULUS);      // table address
    localparam int DIVD_W  = 2 * RES_W;                // product of two units
    localparam int MOD_STEPS = DIVD_W;                 // one quotient bit a step
    localparam int CNT_W   = $clog2(MOD_STEPS + 1);

    // stream widths
    localparam int S_TDATA_W = 2 * RES_W;              // row_rank, col_rank
    localparam int M_TDATA_W = 3 * RES_W;              // count, residue, rank

    // opcode values
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic cap_item;     // capture accepted input transfer
        logic build_init;   // start of build: reset count, set first residue
        logic gcd_load;     // load gcd operands a = n, b = r
        logic mod_start;    // start the remainder unit
        logic mod_query;    // remainder unit operands from the query product
        logic gcd_step;     // a = b, b = a mod b
        logic unit_add;     // store current residue as the next unit
        logic r_inc;        // advance to the next residue
        logic set_built;    // mark list as built
        logic q_err;        // reject the query
        logic rd_col;       // unit table read address from col_rank
        logic cap_ua;       // capture first unit
        logic cap_prod;     // capture product of the two units
        logic cap_residue;  // capture product remainder
        logic cap_rank;     // capture rank of the remainder
        logic out_load;     // load the output register
    } ugm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_build;     // captured item is a build
        logic n_one;        // effective modulus is one
        logic r_end;        // residue walk reached the modulus
        logic b_zero;       // gcd finished
        logic a_one;        // gcd result is one
        logic q_bad;        // query out of range or no list
        logic mod_done;     // remainder ready
        logic out_free;     // output register can take a result
    } ugm_stat_t;

endpackage

// ----- hdl/unit_group_mod_n_product_table.sv -----
// ----------------------------------------------------------------------------
// unit_group_mod_n_product_table
// Builds the sorted unit list of the integers modulo n and answers product
// queries on it: product residue and its one-based rank.
// ----------------------------------------------------------------------------
// Query: dispatch, two unit table reads, the multiply, the bit-serial
// remainder unit and the rank read, then the output register. A rejected
// query goes from dispatch straight to the output. A build with n > 1 tests
// each residue r < n with euclid's gcd(n, r), each step one remainder pass.
// One item is worked at a time; the next is taken in the cycle after the result
// enters the output register. Reset sets n = 1 and clears the built flag and
// the unit count; the tables are not cleared and hold junk until a build.
// ----------------------------------------------------------------------------
module unit_group_mod_n_product_table
    import ugm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: modulus
    input  logic                 cfg_wr_en,
    input  logic [MOD_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] row_rank, [15:8] col_rank
    input  logic [0:0]           s_tuser,   // [0] opcode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] unit_count,
                                            // [15:8] product_residue,
                                            // [23:16] product_rank
    output logic [0:0]           m_tuser    // [0] index_error
);

    ugm_cmd_t  cmd;
    ugm_stat_t stat;

    ugm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ugm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- hdl/ugm_ram.sv -----
// ----------------------------------------------------------------------------
// ugm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ugm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ugm_mod.sv -----
// ----------------------------------------------------------------------------
// ugm_mod
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ugm_mod
    import ugm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [MOD_W-1:0]  divisor,
    output logic [MOD_W-1:0]  remainder,
    output logic              done
);

    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [MOD_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [MOD_W:0]    trial;

    // shifted partial remainder for this step
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};

    // next-state logic for one restoring step
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = CNT_W'(MOD_STEPS);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = MOD_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[MOD_W-1:0];
            end
            quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    // step counter and done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operand and remainder registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

    // remainder is ready once every dividend bit has been stepped after start
    a_done_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> ##(MOD_STEPS + 1) done)
        else $error("remainder unit done out of step");

endmodule

// ----- hdl/ugm_datapath.sv -----
// ----------------------------------------------------------------------------
// ugm_datapath
// Registers, unit and rank tables, remainder unit and output register of the
// unit group product table.
// ----------------------------------------------------------------------------
module ugm_datapath
    import ugm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [MOD_W-1:0]     cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser,
    input  ugm_cmd_t             cmd,
    output ugm_stat_t            stat
);

    // control state
    logic [MOD_W-1:0]  modulus_reg, modulus_next;
    logic              list_built_reg, list_built_next;
    logic [RES_W-1:0]  units_found_reg, units_found_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload state
    logic              opcode_reg, opcode_next;
    logic [RES_W-1:0]  row_reg, row_next;
    logic [RES_W-1:0]  col_reg, col_next;
    logic [MOD_W-1:0]  r_reg, r_next;
    logic [MOD_W-1:0]  a_reg, a_next;
    logic [MOD_W-1:0]  b_reg, b_next;
    logic [RES_W-1:0]  ua_reg, ua_next;
    logic [DIVD_W-1:0] prod_reg, prod_next;
    logic [RES_W-1:0]  residue_reg, residue_next;
    logic [RES_W-1:0]  rank_reg, rank_next;
    logic              err_reg, err_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [0:0]        m_tuser_reg, m_tuser_next;

    logic [MOD_W-1:0]  n_eff;
    logic              n_one;
    logic              out_free;

    // table ports
    logic              tbl_we;
    logic [ADDR_W-1:0] unit_waddr, unit_raddr, rank_waddr, rank_raddr;
    logic [RES_W-1:0]  unit_wdata, unit_rdata, rank_wdata, rank_rdata;

    // remainder unit ports
    logic [DIVD_W-1:0] mod_dividend;
    logic [MOD_W-1:0]  mod_divisor, mod_rem;
    logic              mod_done;

    // effective modulus: zero acts as one, large values saturate
    always_comb begin
        if (modulus_reg == '0) begin
            n_eff = MOD_W'(1);
        end else if (modulus_reg > MOD_W'(MAX_MODULUS)) begin
            n_eff = MOD_W'(MAX_MODULUS);
        end else begin
            n_eff = modulus_reg;
        end
    end

    assign n_one    = (n_eff == MOD_W'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    // status to controller
    always_comb begin
        stat.is_build = (opcode_reg == OP_BUILD);
        stat.n_one    = n_one;
        stat.r_end    = (r_reg == n_eff);
        stat.b_zero   = (b_reg == '0);
        stat.a_one    = (a_reg == MOD_W'(1));
        stat.q_bad    = !list_built_reg || (row_reg >= units_found_reg)
                        || (col_reg >= units_found_reg);
        stat.mod_done = mod_done;
        stat.out_free = out_free;
    end

    // table writes: single unit for modulus one, else one unit per coprime residue
    assign tbl_we     = cmd.unit_add || (cmd.build_init && n_one);
    assign unit_waddr = cmd.build_init ? '0 : units_found_reg;
    assign unit_wdata = cmd.build_init ? RES_W'(1) : r_reg[RES_W-1:0];
    assign rank_waddr = cmd.build_init ? '0 : r_reg[ADDR_W-1:0];
    assign rank_wdata = cmd.build_init ? RES_W'(1) : units_found_reg + RES_W'(1);
    assign unit_raddr = cmd.rd_col ? col_reg : row_reg;
    assign rank_raddr = mod_rem[ADDR_W-1:0];

    ugm_ram #(
        .WIDTH (RES_W),
        .DEPTH (MAX_MODULUS)
    ) u_unit_list (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (unit_waddr),
        .wdata (unit_wdata),
        .raddr (unit_raddr),
        .rdata (unit_rdata)
    );

    ugm_ram #(
        .WIDTH (RES_W),
        .DEPTH (MAX_MODULUS)
    ) u_rank_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    // remainder unit shared by gcd steps and the query product
    assign mod_dividend = cmd.mod_query ? prod_reg : DIVD_W'(a_reg);
    assign mod_divisor  = cmd.mod_query ? n_eff : b_reg;

    ugm_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .remainder (mod_rem),
        .done      (mod_done)
    );

    // next values of configuration, count and flags
    always_comb begin
        modulus_next     = modulus_reg;
        list_built_next  = list_built_reg;
        units_found_next = units_found_reg;
        m_tvalid_next    = m_tvalid_reg;
        if (cfg_wr_en) begin
            modulus_next    = cfg_wr_data;
            list_built_next = 1'b0;
        end
        // list is not valid while it is being rebuilt
        if (cmd.build_init) begin
            list_built_next = 1'b0;
        end
        if (cmd.set_built) begin
            list_built_next = 1'b1;
        end
        if (cmd.build_init) begin
            units_found_next = n_one ? RES_W'(1) : '0;
        end else if (cmd.unit_add) begin
            units_found_next = units_found_reg + RES_W'(1);
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // next values of item, walk and result registers
    always_comb begin
        opcode_next  = opcode_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        r_next       = r_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ua_next      = ua_reg;
        prod_next    = prod_reg;
        residue_next = residue_reg;
        rank_next    = rank_reg;
        err_next     = err_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (cmd.cap_item) begin
            opcode_next = s_tuser[0];
            row_next    = s_tdata[RES_W-1:0];
            col_next    = s_tdata[2*RES_W-1:RES_W];
        end
        if (cmd.build_init) begin
            r_next       = MOD_W'(1);
            residue_next = '0;
            rank_next    = '0;
            err_next     = 1'b0;
        end else if (cmd.r_inc) begin
            r_next = r_reg + MOD_W'(1);
        end
        if (cmd.gcd_load) begin
            a_next = n_eff;
            b_next = r_reg;
        end else if (cmd.gcd_step) begin
            a_next = b_reg;
            b_next = mod_rem;
        end
        if (cmd.cap_ua) begin
            ua_next = unit_rdata;
        end
        if (cmd.cap_prod) begin
            prod_next = DIVD_W'(ua_reg) * DIVD_W'(unit_rdata);
        end
        if (cmd.q_err) begin
            residue_next = '0;
            rank_next    = '0;
            err_next     = 1'b1;
        end
        if (cmd.cap_residue) begin
            residue_next = mod_rem[RES_W-1:0];
            err_next     = 1'b0;
        end
        if (cmd.cap_rank) begin
            rank_next = rank_rdata;
        end
        if (cmd.out_load) begin
            m_tdata_next = {rank_reg, residue_reg, units_found_reg};
            m_tuser_next = err_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= MOD_W'(1);
            list_built_reg  <= 1'b0;
            units_found_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            modulus_reg     <= modulus_next;
            list_built_reg  <= list_built_next;
            units_found_reg <= units_found_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        opcode_reg  <= opcode_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        r_reg       <= r_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        ua_reg      <= ua_next;
        prod_reg    <= prod_next;
        residue_reg <= residue_next;
        rank_reg    <= rank_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a built list is never empty and never longer than the modulus
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        list_built_reg |-> (units_found_reg != '0)
                           && ({1'b0, units_found_reg} <= n_eff))
        else $error("unit count out of bounds for built list");

    // euclid step only with 0 < b < a
    a_gcd_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mod_start && !cmd.mod_query) |-> (b_reg != '0) && (b_reg < a_reg))
        else $error("gcd operands out of order");

    // product of two units is a unit, so its rank was written by the build
    a_rank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_rank |-> (rank_rdata != '0))
        else $error("query product has no rank");

    // never overwrite a result still waiting on the output
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");

endmodule

// ----- hdl/ugm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ugm_ctrl
// Controller state machine: sequences the residue walk with gcd for a build
// and the table reads, multiply and remainder for a query.
// ----------------------------------------------------------------------------
module ugm_ctrl
    import ugm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      in_ready,
    input  ugm_stat_t stat,
    output ugm_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_B_CHECK  = 11'b000_0000_0100,
        S_G_TEST   = 11'b000_0000_1000,
        S_G_WAIT   = 11'b000_0001_0000,
        S_Q_RD1    = 11'b000_0010_0000,
        S_Q_RD2    = 11'b000_0100_0000,
        S_Q_MODS   = 11'b000_1000_0000,
        S_Q_MODW   = 11'b001_0000_0000,
        S_Q_RANK   = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } ugm_state_t;

    ugm_state_t state_reg, state_next;

    // input side is open only between items
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_build) begin
                    cmd.build_init = 1'b1;
                    if (stat.n_one) begin
                        cmd.set_built = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        state_next = S_B_CHECK;
                    end
                end else if (stat.q_bad) begin
                    cmd.q_err  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_Q_RD1;
                end
            end
            S_B_CHECK: begin
                if (stat.r_end) begin
                    cmd.set_built = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    cmd.gcd_load = 1'b1;
                    state_next   = S_G_TEST;
                end
            end
            S_G_TEST: begin
                if (stat.b_zero) begin
                    cmd.unit_add = stat.a_one;
                    cmd.r_inc    = 1'b1;
                    state_next   = S_B_CHECK;
                end else begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_G_WAIT;
                end
            end
            S_G_WAIT: begin
                if (stat.mod_done) begin
                    cmd.gcd_step = 1'b1;
                    state_next   = S_G_TEST;
                end
            end
            S_Q_RD1: begin
                cmd.cap_ua = 1'b1;
                cmd.rd_col = 1'b1;
                state_next = S_Q_RD2;
            end
            S_Q_RD2: begin
                cmd.cap_prod = 1'b1;
                state_next   = S_Q_MODS;
            end
            S_Q_MODS: begin
                cmd.mod_start = 1'b1;
                cmd.mod_query = 1'b1;
                state_next    = S_Q_MODW;
            end
            S_Q_MODW: begin
                if (stat.mod_done) begin
                    cmd.cap_residue = 1'b1;
                    state_next      = S_Q_RANK;
                end
            end
            S_Q_RANK: begin
                cmd.cap_rank = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- verif/unit_group_mod_n_product_table_tb.sv -----
// ----------------------------------------------------------------------------
// unit_group_mod_n_product_table_tb
// Self-checking bench for the unit group product table. A predictor inside
// the bench rebuilds the unit list on every build transfer and works out each
// query answer. Every result transfer is checked in order against it. Both
// stream sides idle at random, and directed tests cover the reset state,
// modulus zero and saturation, small and prime moduli, and output stalls.
// ----------------------------------------------------------------------------
module unit_group_mod_n_product_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ugm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 300000;
    localparam int unsigned RANDOM_ITEMS   = 1350;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned REBUILD_MAX_N  = 64;

    // one result transfer, split into its fields
    typedef struct packed {
        logic [RES_W-1:0] unit_count;
        logic [RES_W-1:0] product_residue;
        logic [RES_W-1:0] product_rank;
        logic             index_error;
    } group_answer_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [MOD_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // [7:0] row_rank, [15:8] col_rank
    logic [0:0]           s_tuser;      // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;      // [7:0] unit_count, [15:8] product_residue,
                                        // [23:16] product_rank
    logic [0:0]           m_tuser;      // [0] index_error

    // predictor copy of the register and the tables
    logic [MOD_W-1:0] model_modulus;
    logic [RES_W-1:0] model_units [MAX_MODULUS];
    logic [RES_W-1:0] model_rank  [MAX_MODULUS];
    int unsigned      model_count;
    bit               model_built;

    group_answer_t pending_answers [$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles    = 0;
    int unsigned   rx_hold_len    = 0;
    bit            tx_gaps_on     = 1'b1;
    bit            rx_gaps_on     = 1'b1;

    unit_group_mod_n_product_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero acts as one, anything past the table size saturates
    function automatic int unsigned effective_modulus();
        if (model_modulus == 0) begin
            return 1;
        end
        if (model_modulus > MAX_MODULUS) begin
            return MAX_MODULUS;
        end
        return model_modulus;
    endfunction

    function automatic int unsigned euclid_gcd(input int unsigned a, input int unsigned b);
        int unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // walk residues 1..n-1 in ascending order and keep the coprime ones
    function automatic void rebuild_unit_list();
        int unsigned n;
        int unsigned r;
        n = effective_modulus();
        model_count = 0;
        foreach (model_rank[i]) begin
            model_rank[i] = '0;
        end
        if (n == 1) begin
            // the trivial group: residue 0 is the identity
            model_units[0] = 1;
            model_rank[0]  = 1;
            model_count    = 1;
        end else begin
            for (r = 1; r < n; r++) begin
                if (euclid_gcd(n, r) == 1) begin
                    model_units[model_count] = RES_W'(r);
                    model_count++;
                    model_rank[r] = RES_W'(model_count);
                end
            end
        end
        model_built = 1'b1;
    endfunction

    function automatic group_answer_t unit_group_answer(input logic op,
                                                        input logic [RES_W-1:0] row,
                                                        input logic [RES_W-1:0] col);
        group_answer_t ans;
        int unsigned   n;
        int unsigned   prod;
        ans = '0;
        if (op == OP_BUILD) begin
            rebuild_unit_list();
        end else if (!model_built || row >= model_count || col >= model_count) begin
            ans.index_error = 1'b1;
        end else begin
            n    = effective_modulus();
            prod = int'(model_units[row]) * int'(model_units[col]);
            ans.product_residue = RES_W'(prod % n);
            ans.product_rank    = model_rank[prod % n];
        end
        ans.unit_count = RES_W'(model_count);
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------------

    // offer one item after a random gap, predict it once accepted
    task automatic send_item(input logic op, input logic [RES_W-1:0] row,
                             input logic [RES_W-1:0] col);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, row};
        do @(posedge aclk); while (!s_tready);
        pending_answers.insert(pending_answers.size(), unit_group_answer(op, row, col));
    endtask

    // stop offering and wait for every outstanding answer
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_modulus(input logic [MOD_W-1:0] value);
        drain_answers();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        model_modulus  = value;
        model_built    = 1'b0;
    endtask

    // result side: random stalls, plus a long hold when a test asks for it
    initial begin : result_sink
        int unsigned pause;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            pause = rx_gaps_on ? $urandom_range(0, 15) : 0;
            if (rx_hold_len != 0) begin
                pause       = rx_hold_len;
                rx_hold_len = 0;
            end
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && rx_hold_len == 0);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : check_answers
        group_answer_t want;
        group_answer_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.unit_count      = m_tdata[7:0];
            got.product_residue = m_tdata[15:8];
            got.product_rank    = m_tdata[23:16];
            got.index_error     = m_tuser[0];
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result count %0d residue %0d rank %0d err %0b",
                             $realtime, got.unit_count, got.product_residue,
                             got.product_rank, got.index_error);
                end
            end else begin
                want = pending_answers.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch want count %0d residue %0d rank %0d err %0b",
                                 $realtime, want.unit_count, want.product_residue,
                                 want.product_rank, want.index_error);
                        $display("%0t:            got count %0d residue %0d rank %0d err %0b",
                                 $realtime, got.unit_count, got.product_residue,
                                 got.product_rank, got.index_error);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // queries before any build, then the default modulus of one
    task automatic test_before_build();
        send_item(OP_QUERY, 8'd0, 8'd0);
        send_item(OP_BUILD, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd1, 8'd0);
        send_item(OP_QUERY, 8'd0, 8'd255);
    endtask

    // modulus zero behaves as one; a write drops the built list
    task automatic test_modulus_zero();
        write_modulus(9'd0);
        send_item(OP_QUERY, 8'd0, 8'd0);
        send_item(OP_BUILD, 8'hff, 8'hff);
        send_item(OP_QUERY, 8'd0, 8'd0);
    endtask

    task automatic test_small_moduli();
        write_modulus(9'd2);
        send_item(OP_BUILD, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd0, 8'd0);
        // units of 12 are 1, 5, 7, 11
        write_modulus(9'd12);
        send_item(OP_BUILD, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd3, 8'd3);
        send_item(OP_QUERY, 8'd1, 8'd2);
        send_item(OP_QUERY, 8'd4, 8'd0);
    endtask

    // all-ones register saturates to the table size, then the largest prime
    task automatic test_saturated_modulus();
        write_modulus(9'h1ff);
        send_item(OP_BUILD, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd127, 8'd127);
        send_item(OP_QUERY, 8'd128, 8'd0);
        write_modulus(9'd251);
        send_item(OP_BUILD, 8'd0, 8'd0);
        send_item(OP_QUERY, 8'd249, 8'd249);
        send_item(OP_QUERY, 8'd250, 8'd0);
        send_item(OP_QUERY, 8'd255, 8'd255);
        send_item(OP_QUERY, 8'd200, 8'd131);
    endtask

    // hold the result side while the sender keeps offering back to back
    task automatic test_output_backpressure();
        int unsigned k;
        drain_answers();
        tx_gaps_on  = 1'b0;
        rx_hold_len = 400;
        for (k = 0; k < 8; k++) begin
            send_item(OP_QUERY, RES_W'($urandom_range(0, model_count - 1)),
                      RES_W'($urandom_range(0, model_count - 1)));
        end
        tx_gaps_on = 1'b1;
    endtask

    // phases of one modulus each: mostly a build first, then mostly in-range queries
    task automatic test_random_phases();
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      pause_at;
        int unsigned      pick;
        int unsigned      big_left;
        int unsigned      k;
        logic [MOD_W-1:0] n_pick;
        logic [RES_W-1:0] row;
        logic [RES_W-1:0] col;
        logic             op;
        sent     = 0;
        big_left = 3;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                n_pick = '0;
            end else if (pick == 1) begin
                n_pick = 9'd1;
            end else if (pick <= 3 && big_left > 0) begin
                n_pick = MOD_W'($urandom_range(REBUILD_MAX_N + 1, 511));
                big_left--;
            end else begin
                n_pick = MOD_W'($urandom_range(2, REBUILD_MAX_N));
            end
            write_modulus(n_pick);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            phase_len  = $urandom_range(40, 90);
            pause_at   = $urandom_range(1, phase_len - 1);
            for (k = 0; k < phase_len; k++) begin
                // sender waits for every answer once per phase
                if (k == pause_at) begin
                    drain_answers();
                end
                pick = $urandom_range(0, 99);
                row  = RES_W'($urandom);
                col  = RES_W'($urandom);
                if (!model_built) begin
                    op = (pick < 10) ? OP_QUERY : OP_BUILD;
                end else if (pick < 4 && effective_modulus() <= REBUILD_MAX_N) begin
                    op = OP_BUILD;
                end else begin
                    op = OP_QUERY;
                    // mostly legal ranks, the rest anywhere in the field
                    if (pick < 88) begin
                        row = RES_W'($urandom_range(0, model_count - 1));
                        col = RES_W'($urandom_range(0, model_count - 1));
                    end
                end
                send_item(op, row, col);
                sent++;
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        model_modulus = 9'd1;
        model_count   = 0;
        model_built   = 1'b0;
        foreach (model_units[i]) begin
            model_units[i] = '0;
            model_rank[i]  = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_build();
        test_modulus_zero();
        test_small_moduli();
        test_saturated_modulus();
        test_output_backpressure();
        test_random_phases();

        drain_answers();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
